FILE: design/blzd_pkg.sv
package blzd_pkg;

  localparam int unsigned HIST_DEPTH = 2048;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned MLEN_W     = 12;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = $clog2(QDEPTH);

  localparam logic [MLEN_W-1:0] PROD_MAX  = '1;
  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TOKEN = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_TOKEN,
    KIND_PULL,
    KIND_BAD
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CTRL,
    PH_LD,
    PH_LOW
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_TOO_LONG,
    ST_DIST,
    ST_LEFTOVER,
    ST_ORDER
  } status_e;

  // One classified input item waiting in the queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result on its way to the output, with its history ring access.
  typedef struct packed {
    logic               store;
    logic               copy;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] raddr;
    logic [HIST_AW-1:0] waddr;
    logic [LEN_W-1:0]   idx;
    logic               fin;
    status_e            status;
  } res_t;

endpackage

FILE: design/backward_lz_escape_decoder.sv
// Backward LZ decoder with an escape byte. Feed a start item (tuser 0, escape
// byte in tdata), then the token stream from its end towards its start (tuser 1,
// tlast on the final byte), and one pull (tuser 2) for each byte of a pending
// match. Every literal, every pulled byte and every error produces one output
// transfer; plaintext comes out backward from index output_length-1 down to 0,
// and an error code in tuser stays sticky until the next start. Write
// output_length on the configuration channel while the block is idle; it is
// sampled by the start item. The block takes one item per clock cycle, pulls
// included, as long as the output does not hold it back; the single write port
// and registered read port of the 2048-byte history ring allow this. An item's
// result leaves through the result buffer and then the output register, and a
// four-entry input queue plus the output register decouple the two sides.
module backward_lz_escape_decoder import blzd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // data
  input  logic             s_axis_tlast_i,
  input  logic [1:0]       s_axis_tuser_i,   // cmd
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // out_byte, out_index
  output logic             m_axis_tlast_o,
  output logic [2:0]       m_axis_tuser_o    // status
);

  logic  head_valid;
  item_t head;
  logic  pop;
  logic  res_valid;
  res_t  res;
  logic  res_ready;

  assign cfg_ready_o = 1'b1;

  blzd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  blzd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  blzd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

FILE: design/blzd_front.sv
module blzd_front import blzd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       head_valid_o,
  output item_t      head_o,
  input  logic       pop_i
);

  item_t          entry_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;
  logic           push;
  logic           pop;
  item_t          new_item;

  always_comb begin
    new_item.data = in_data_i;
    new_item.last = in_last_i;
    case (in_cmd_i)
      CMD_START: new_item.kind = KIND_START;
      CMD_TOKEN: new_item.kind = KIND_TOKEN;
      CMD_PULL:  new_item.kind = KIND_PULL;
      default:   new_item.kind = KIND_BAD;
    endcase
  end

  assign in_ready_o   = (count_q != (QAW+1)'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: design/blzd_core.sv
module blzd_core import blzd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_ready_i
);

  logic [LEN_W-1:0]  out_len_q;
  logic [7:0]        esc_q, esc_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [7:0]        ldb_q, ldb_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [MLEN_W-1:0] mrem_q, mrem_d;
  logic [MLEN_W-1:0] mdist_q, mdist_d;
  logic              ended_q, ended_d;
  logic              failed_q, failed_d;
  status_e           err_q, err_d;
  logic [MLEN_W-1:0] prod_q, prod_d;

  logic              res_valid;
  res_t              res;
  logic [LEN_W-1:0]  pos;
  logic              pos_zero;
  logic [MLEN_W-1:0] prod_inc;
  logic [MLEN_W-1:0] mrem_dec;
  logic              do_lit;
  logic [7:0]        lit_v;
  logic              do_match;
  logic [MLEN_W-1:0] m_len;
  logic [MLEN_W-1:0] m_dist;
  logic              mid_token;
  logic              fail_en;
  status_e           fail_code;

  assign pos      = rem_q - LEN_W'(1);
  assign pos_zero = (rem_q == LEN_W'(1));
  assign prod_inc = (prod_q != PROD_MAX) ? prod_q + MLEN_W'(1) : prod_q;
  assign mrem_dec = mrem_q - MLEN_W'(1);

  always_comb begin
    esc_d     = esc_q;
    phase_d   = phase_q;
    ctrl_d    = ctrl_q;
    ldb_d     = ldb_q;
    rem_d     = rem_q;
    mrem_d    = mrem_q;
    mdist_d   = mdist_q;
    ended_d   = ended_q;
    failed_d  = failed_q;
    err_d     = err_q;
    prod_d    = prod_q;
    res_valid = 1'b0;
    do_lit    = 1'b0;
    lit_v     = head_i.data;
    do_match  = 1'b0;
    m_len     = MLEN_W'(3);
    m_dist    = {4'd0, head_i.data};
    mid_token = 1'b0;
    fail_en   = 1'b0;
    fail_code = ST_ORDER;

    res.store  = 1'b0;
    res.copy   = 1'b0;
    res.lit    = head_i.data;
    res.raddr  = HIST_AW'(pos) + HIST_AW'(mdist_q);
    res.waddr  = HIST_AW'(pos);
    res.idx    = pos;
    res.fin    = 1'b0;
    res.status = ST_OK;

    if (head_i.kind == KIND_START) begin
      esc_d    = head_i.data;
      phase_d  = PH_IDLE;
      ctrl_d   = '0;
      ldb_d    = '0;
      rem_d    = out_len_q;
      mrem_d   = '0;
      mdist_d  = '0;
      ended_d  = 1'b0;
      failed_d = 1'b0;
      err_d    = ST_OK;
      prod_d   = '0;
    end else if (failed_q) begin
      res_valid  = 1'b1;
      res.idx    = '0;
      res.status = err_q;
    end else if (head_i.kind == KIND_TOKEN) begin
      if (mrem_q != '0 || ended_q) begin
        fail_en   = 1'b1;
        fail_code = ST_ORDER;
      end else if (rem_q == '0) begin
        fail_en   = 1'b1;
        fail_code = ST_LEFTOVER;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (head_i.data != esc_q) begin
              do_lit = 1'b1;
            end else begin
              phase_d   = PH_CTRL;
              mid_token = 1'b1;
            end
          end
          PH_CTRL: begin
            if (head_i.data == 8'd0) begin
              do_lit = 1'b1;
              lit_v  = esc_q;
            end else if (!head_i.data[7]) begin
              do_match = 1'b1;
            end else begin
              ctrl_d    = head_i.data;
              phase_d   = PH_LD;
              mid_token = 1'b1;
            end
          end
          PH_LD: begin
            m_dist = {1'b0, ctrl_q[6:0], head_i.data[3:0]} + MLEN_W'(1);
            m_len  = MLEN_W'(head_i.data[6:4]) + MLEN_W'(4);
            if (!head_i.data[7]) begin
              do_match = 1'b1;
            end else begin
              ldb_d     = head_i.data;
              phase_d   = PH_LOW;
              mid_token = 1'b1;
            end
          end
          default: begin
            m_dist   = {1'b0, ctrl_q[6:0], ldb_q[3:0]} + MLEN_W'(1);
            m_len    = {1'b0, ldb_q[6:4], head_i.data} + MLEN_W'(12);
            do_match = 1'b1;
          end
        endcase
      end

      if (do_lit) begin
        phase_d    = PH_IDLE;
        rem_d      = pos;
        prod_d     = prod_inc;
        res_valid  = 1'b1;
        res.store  = 1'b1;
        res.lit    = lit_v;
        res.fin    = pos_zero;
        if (head_i.last) begin
          ended_d = 1'b1;
        end
        if (pos_zero != head_i.last) begin
          fail_en   = 1'b1;
          fail_code = pos_zero ? ST_LEFTOVER : ST_TRUNC;
        end
      end

      if (do_match) begin
        phase_d = PH_IDLE;
        if (head_i.last) begin
          ended_d = 1'b1;
        end
        if (LEN_W'(m_len) > rem_q) begin
          fail_en   = 1'b1;
          fail_code = ST_TOO_LONG;
        end else begin
          mrem_d  = m_len;
          mdist_d = m_dist;
        end
      end

      if (mid_token && head_i.last) begin
        ended_d   = 1'b1;
        fail_en   = 1'b1;
        fail_code = ST_TRUNC;
      end
    end else if (head_i.kind == KIND_PULL) begin
      if (mrem_q == '0 || rem_q == '0) begin
        fail_en   = 1'b1;
        fail_code = ST_ORDER;
      end else if (mdist_q > prod_q) begin
        fail_en   = 1'b1;
        fail_code = ST_DIST;
      end else begin
        rem_d     = pos;
        prod_d    = prod_inc;
        mrem_d    = mrem_dec;
        res_valid = 1'b1;
        res.store = 1'b1;
        res.copy  = 1'b1;
        res.fin   = pos_zero;
        if (pos_zero && !ended_q) begin
          fail_en   = 1'b1;
          fail_code = ST_LEFTOVER;
        end else if (!pos_zero && mrem_dec == '0 && ended_q) begin
          fail_en   = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
    end else begin
      fail_en   = 1'b1;
      fail_code = ST_ORDER;
    end

    // An error result still lets any store go ahead, but carries zeroes.
    if (fail_en) begin
      res_valid  = 1'b1;
      failed_d   = 1'b1;
      err_d      = fail_code;
      res.idx    = '0;
      res.fin    = 1'b0;
      res.status = fail_code;
    end
  end

  assign pop_o       = head_valid_i && (!res_valid || res_ready_i);
  assign res_valid_o = head_valid_i && res_valid;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= LEN_RESET;
      esc_q     <= '0;
      phase_q   <= PH_IDLE;
      ctrl_q    <= '0;
      ldb_q     <= '0;
      rem_q     <= '0;
      mrem_q    <= '0;
      mdist_q   <= '0;
      ended_q   <= 1'b0;
      failed_q  <= 1'b0;
      err_q     <= ST_OK;
      prod_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        out_len_q <= cfg_data_i;
      end
      if (pop_o) begin
        esc_q    <= esc_d;
        phase_q  <= phase_d;
        ctrl_q   <= ctrl_d;
        ldb_q    <= ldb_d;
        rem_q    <= rem_d;
        mrem_q   <= mrem_d;
        mdist_q  <= mdist_d;
        ended_q  <= ended_d;
        failed_q <= failed_d;
        err_q    <= err_d;
        prod_q   <= prod_d;
      end
    end
  end

endmodule

FILE: design/blzd_emit.sv
module blzd_emit import blzd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  res_t              res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LEN_W+7:0]  out_data_o,
  output logic              out_last_o,
  output logic [2:0]        out_user_o
);

  logic [7:0]        ring_q [HIST_DEPTH];
  logic [7:0]        rdata_q;
  logic              fwd_q;
  logic [7:0]        fwd_byte_q;
  logic              b_valid_q;
  res_t              b_q;
  logic [7:0]        b_byte;
  logic              b_leave;
  logic              take;
  logic              o_valid_q;
  logic [LEN_W+7:0]  o_data_q;
  logic              o_last_q;
  logic [2:0]        o_user_q;

  assign b_byte      = !b_q.copy ? b_q.lit : (fwd_q ? fwd_byte_q : rdata_q);
  assign b_leave     = b_valid_q && (!o_valid_q || out_ready_i);
  assign res_ready_o = !b_valid_q || b_leave;
  assign take        = res_valid_i && res_ready_o;

  // The ring write of the leaving result and the read of the entering one
  // share an edge, so a matching address is served from the written byte.
  always_ff @(posedge clk_i) begin
    if (b_leave && b_q.store) begin
      ring_q[b_q.waddr] <= b_byte;
    end
    if (take) begin
      rdata_q    <= ring_q[res_i.raddr];
      fwd_q      <= b_leave && b_q.store && (b_q.waddr == res_i.raddr);
      fwd_byte_q <= b_byte;
      b_q        <= res_i;
    end
    if (b_leave) begin
      o_data_q <= {b_q.idx, (b_q.status == ST_OK) ? b_byte : 8'd0};
      o_last_q <= b_q.fin;
      o_user_q <= b_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (take) begin
        b_valid_q <= 1'b1;
      end else if (b_leave) begin
        b_valid_q <= 1'b0;
      end
      if (b_leave) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;
  assign out_last_o  = o_last_q;
  assign out_user_o  = o_user_q;

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import blzd_pkg::*;

  typedef struct packed {
    logic [7:0]       value;
    logic [LEN_W-1:0] pos;
    logic             fin;
    status_e          status;
  } plain_res_t;

  class plaintext_scoreboard;
    logic [LEN_W-1:0]  out_len;
    logic [7:0]        esc;
    phase_e            phase;
    logic [7:0]        ctrl;
    logic [7:0]        ld;
    logic [LEN_W-1:0]  bytes_left;
    logic [MLEN_W-1:0] match_left;
    logic [MLEN_W-1:0] match_dist;
    logic [MLEN_W-1:0] produced;
    logic              ended;
    logic              failed;
    status_e           err;
    logic [7:0]        ring [HIST_DEPTH];
    plain_res_t        expected_bytes [$];
    int                checked;
    int                errors;

    function new();
      out_len    = LEN_RESET;
      esc        = '0;
      phase      = PH_IDLE;
      ctrl       = '0;
      ld         = '0;
      bytes_left = '0;
      match_left = '0;
      match_dist = '0;
      produced   = '0;
      ended      = 1'b0;
      failed     = 1'b0;
      err        = ST_OK;
      checked    = 0;
      errors     = 0;
    endfunction

    function bit raise(status_e code, output plain_res_t r);
      failed = 1'b1;
      err    = code;
      r      = '{8'd0, '0, 1'b0, code};
      return 1'b1;
    endfunction

    function void store_byte(logic [LEN_W-1:0] pos, logic [7:0] v);
      ring[pos[HIST_AW-1:0]] = v;
      bytes_left = pos;
      if (produced != PROD_MAX) produced++;
    endfunction

    function bit put_literal(logic [7:0] v, logic last, output plain_res_t r);
      logic [LEN_W-1:0] pos;
      pos   = bytes_left - 1'b1;
      phase = PH_IDLE;
      store_byte(pos, v);
      if (last) ended = 1'b1;
      if (pos == 0) begin
        if (!last) return raise(ST_LEFTOVER, r);
        r = '{v, pos, 1'b1, ST_OK};
        return 1'b1;
      end
      if (last) return raise(ST_TRUNC, r);
      r = '{v, pos, 1'b0, ST_OK};
      return 1'b1;
    endfunction

    // A complete match token produces nothing unless the match cannot fit.
    function bit begin_match(logic [MLEN_W-1:0] len, logic [MLEN_W-1:0] distance, logic last,
                             output plain_res_t r);
      phase = PH_IDLE;
      if (last) ended = 1'b1;
      if (len > bytes_left) return raise(ST_TOO_LONG, r);
      match_left = len;
      match_dist = distance;
      return 1'b0;
    endfunction

    function bit decode_item(logic [1:0] cmd, logic [7:0] data, logic last,
                             output plain_res_t r);
      logic [MLEN_W-1:0]  distance;
      logic [MLEN_W-1:0]  len;
      logic [LEN_W-1:0]   pos;
      logic [HIST_AW-1:0] addr;
      logic [7:0]         v;
      if (cmd == CMD_START) begin
        esc        = data;
        phase      = PH_IDLE;
        ctrl       = '0;
        ld         = '0;
        bytes_left = out_len;
        match_left = '0;
        match_dist = '0;
        ended      = 1'b0;
        failed     = 1'b0;
        err        = ST_OK;
        produced   = '0;
        return 1'b0;
      end
      if (failed) begin
        r = '{8'd0, '0, 1'b0, err};
        return 1'b1;
      end
      if (cmd == CMD_TOKEN) begin
        if (match_left != 0 || ended) return raise(ST_ORDER, r);
        if (bytes_left == 0) return raise(ST_LEFTOVER, r);
        case (phase)
          PH_IDLE: begin
            if (data != esc) return put_literal(data, last, r);
            phase = PH_CTRL;
          end
          PH_CTRL: begin
            if (data == 8'd0) return put_literal(esc, last, r);
            if (!data[7]) return begin_match(MLEN_W'(3), MLEN_W'(data), last, r);
            ctrl  = data;
            phase = PH_LD;
          end
          PH_LD: begin
            distance = MLEN_W'({ctrl[6:0], data[3:0]}) + 1'b1;
            if (!data[7]) begin
              len = MLEN_W'(data[6:4]) + MLEN_W'(4);
              return begin_match(len, distance, last, r);
            end
            ld    = data;
            phase = PH_LOW;
          end
          default: begin
            distance = MLEN_W'({ctrl[6:0], ld[3:0]}) + 1'b1;
            len      = MLEN_W'({ld[6:4], data}) + MLEN_W'(12);
            return begin_match(len, distance, last, r);
          end
        endcase
        // The stream ran out in the middle of a token.
        if (last) begin
          ended = 1'b1;
          return raise(ST_TRUNC, r);
        end
        return 1'b0;
      end
      if (cmd == CMD_PULL) begin
        if (match_left == 0 || bytes_left == 0) return raise(ST_ORDER, r);
        if (match_dist > produced) return raise(ST_DIST, r);
        pos  = bytes_left - 1'b1;
        addr = pos[HIST_AW-1:0] + match_dist[HIST_AW-1:0];
        v    = ring[addr];
        store_byte(pos, v);
        match_left--;
        if (pos == 0) begin
          if (!ended) return raise(ST_LEFTOVER, r);
          r = '{v, pos, 1'b1, ST_OK};
          return 1'b1;
        end
        if (match_left == 0 && ended) return raise(ST_TRUNC, r);
        r = '{v, pos, 1'b0, ST_OK};
        return 1'b1;
      end
      return raise(ST_ORDER, r);
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] data, logic last);
      plain_res_t r;
      if (decode_item(cmd, data, last, r)) expected_bytes.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_output(logic [31:0] tdata, logic tlast, logic [2:0] tuser);
      plain_res_t e;
      checked++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: output transfer with nothing expected, expected none actual %h/%h",
                   $time, tdata, tuser);
        return;
      end
      e = expected_bytes.pop_front();
      if (tdata[7:0] !== e.value) report("out_byte", 32'(e.value), 32'(tdata[7:0]));
      if (tdata[31:8] !== e.pos) report("out_index", 32'(e.pos), 32'(tdata[31:8]));
      if (tlast !== e.fin) report("final", 32'(e.fin), 32'(tlast));
      if (tuser !== e.status) report("status", 32'(e.status), 32'(tuser));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i;   // data
  logic             s_axis_tlast_i;
  logic [1:0]       s_axis_tuser_i;   // cmd
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [31:0]      m_axis_tdata_o;   // out_byte, out_index
  logic             m_axis_tlast_o;
  logic [2:0]       m_axis_tuser_o;   // status

  plaintext_scoreboard sb;
  int burst_left  = 0;
  int items_sent  = 0;
  int settings    = 0;
  int cur_length  = 1;
  int rx_mode     = 0;
  int rx_mode_left = 0;
  int rx_tick     = 0;

  backward_lz_escape_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5ns clk_i = ~clk_i;

  // Receiver: check every output transfer, then pick the next ready value from
  // a stall pattern that is drawn anew from four modes at random intervals.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1)
      sb.check_output(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ((rx_tick % 16) >= 10);
    endcase
  end

  function automatic int min_int(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Sender: bursts of back-to-back transfers separated by random gaps.
  task automatic send(input logic [1:0] cmd, input logic [7:0] data, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= data;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    sb.note_item(cmd, data, last);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_pulls(input int n);
    repeat (n) send(CMD_PULL, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and let every expected result arrive, plus time for items
  // that produce nothing to leave the pipeline.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.out_len = len;
    cur_length = int'(len);
    settings++;
  endtask

  // One block of well-formed tokens with random content, optionally salted
  // with random items that break the sequence.
  task automatic run_block(input logic [7:0] esc, input int max_tokens, input int max_len,
                           input int noise_pct);
    int          rem;
    int          prod;
    int          ntok;
    int          len;
    int          distance;
    int          pick;
    logic [7:0]  v;
    logic [10:0] lfield;
    logic [10:0] dfield;
    send(CMD_START, esc, 1'b0);
    rem  = cur_length;
    prod = 0;
    ntok = 0;
    while (rem > 0 && ntok < max_tokens) begin
      if ($urandom_range(0, 99) < noise_pct)
        send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      len  = 1;
      if (pick >= 5 && prod > 0 && rem >= 3) begin
        if (pick == 9 && rem >= 12) begin
          len      = $urandom_range(12, min_int(min_int(rem, max_len), 2059));
          distance = $urandom_range(1, min_int(prod, 2048));
          lfield   = 11'(len - 12);
          dfield   = 11'(distance - 1);
          send(CMD_TOKEN, esc, 1'b0);
          send(CMD_TOKEN, {1'b1, dfield[10:4]}, 1'b0);
          send(CMD_TOKEN, {1'b1, lfield[10:8], dfield[3:0]}, 1'b0);
          send(CMD_TOKEN, lfield[7:0], rem == len);
        end else if (pick >= 7 && rem >= 4) begin
          len      = $urandom_range(4, min_int(rem, 11));
          distance = $urandom_range(1, min_int(prod, 2048));
          lfield   = 11'(len - 4);
          dfield   = 11'(distance - 1);
          send(CMD_TOKEN, esc, 1'b0);
          send(CMD_TOKEN, {1'b1, dfield[10:4]}, 1'b0);
          send(CMD_TOKEN, {1'b0, lfield[2:0], dfield[3:0]}, rem == len);
        end else begin
          len      = 3;
          distance = $urandom_range(1, min_int(prod, 127));
          send(CMD_TOKEN, esc, 1'b0);
          send(CMD_TOKEN, 8'(distance), rem == len);
        end
        send_pulls(len);
      end else if (pick == 4) begin
        send(CMD_TOKEN, esc, 1'b0);
        send(CMD_TOKEN, 8'd0, rem == 1);
      end else begin
        do v = 8'($urandom); while (v == esc);
        send(CMD_TOKEN, v, rem == 1);
      end
      rem  -= len;
      prod += len;
      ntok++;
    end
  endtask

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int          r;
    int          len;
    int          noise;
    logic [7:0]  esc;
    sb = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tuser_i  = CMD_START;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting at the reset length of one.
    send(CMD_TOKEN, 8'h12, 1'b0);           // token before any start
    send(CMD_START, 8'h00, 1'b0);
    send(CMD_TOKEN, 8'hFF, 1'b1);           // one-byte plaintext, completes cleanly
    send(CMD_TOKEN, 8'h7F, 1'b0);           // token after the final stream byte
    send(CMD_START, 8'h80, 1'b0);
    send(CMD_TOKEN, 8'h7F, 1'b0);           // plaintext done with stream left over
    write_length(LEN_W'(20));
    send(CMD_START, 8'hFF, 1'b0);
    send(CMD_TOKEN, 8'h00, 1'b0);
    send(CMD_TOKEN, 8'hFF, 1'b0);
    send(CMD_TOKEN, 8'h00, 1'b0);           // escaped literal
    send(CMD_TOKEN, 8'hFF, 1'b0);
    send(CMD_TOKEN, 8'h80, 1'b0);
    send(CMD_TOKEN, 8'h31, 1'b0);           // long match, length 7, distance 2
    send(CMD_PULL, 8'h00, 1'b0);
    send(CMD_TOKEN, 8'h7F, 1'b0);           // token while a match is pending
    send(CMD_PULL, 8'hFF, 1'b1);            // error stays sticky
    send(CMD_START, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'hFF, 1'b0);
    send(CMD_TOKEN, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h81, 1'b0);
    send(CMD_TOKEN, 8'hF0, 1'b0);
    send(CMD_TOKEN, 8'h05, 1'b0);           // match longer than what remains
    send(CMD_START, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h11, 1'b0);
    send(CMD_TOKEN, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h05, 1'b0);
    send(CMD_PULL, 8'h00, 1'b0);            // distance beyond the bytes produced
    send(CMD_START, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h5A, 1'b1);           // stream ends inside a token
    send(CMD_START, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h11, 1'b0);
    send(CMD_TOKEN, 8'h5A, 1'b0);
    send(CMD_TOKEN, 8'h01, 1'b1);           // short match as the last token ...
    send_pulls(3);                          // ... truncated on its final pull
    send(CMD_START, 8'h5A, 1'b0);
    send(KIND_BAD, 8'h00, 1'b0);            // unknown command

    // Random part: phases of one length setting each, several blocks per phase.
    while (items_sent < 800) begin
      r = $urandom_range(0, 19);
      if (r < 2) len = 1;
      else if (r == 2) len = 24'hFFFFFF;
      else if (r < 12) len = $urandom_range(2, 12);
      else len = $urandom_range(13, 80);
      write_length(LEN_W'(len));
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 5);
        if (r == 0) esc = 8'h00;
        else if (r == 1) esc = 8'hFF;
        else esc = 8'($urandom);
        r = $urandom_range(0, 9);
        noise = (r < 7) ? 0 : ((r < 9) ? 3 : 25);
        if (len == 24'hFFFFFF) run_block(esc, $urandom_range(3, 15), 40, noise);
        else run_block(esc, 100000, 2059, noise);
        if ($urandom_range(0, 4) == 0)
          send($urandom_range(0, 1) ? CMD_TOKEN : CMD_PULL, 8'($urandom),
               1'($urandom_range(0, 1)));
      end
    end

    drain();
    $display("testbench summary: %0d items over %0d length settings, %0d results checked",
             items_sent, settings, sb.checked);
    $display("testbench summary: %0d mismatches", sb.errors);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: backward_lz_escape_decoder.f
design/blzd_pkg.sv
design/blzd_front.sv
design/blzd_core.sv
design/blzd_emit.sv
design/backward_lz_escape_decoder.sv
dv/testbench.sv
